### rtl/rsb_pkg.sv
// Shared types, codes and the sine table for the rotate-and-scale sampler.
package rsb_pkg;

    typedef enum logic [2:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_CENTER_X   = 3'd2,
        CFG_CENTER_Y   = 3'd3,
        CFG_ZOOM       = 3'd4,
        CFG_ANGLE      = 3'd5
    } t_cfg_idx;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // quotient bits kept by the divider; the source is at most 511 wide
    localparam int QW = 9;
    localparam int FRAC = 14;

    typedef struct packed {
        logic        vld;
        logic        cmd;
        logic [15:0] idx;
        logic [7:0]  val;
        logic [9:0]  dx;
        logic [9:0]  dy;
        logic        ok;
    } t_item;

    localparam logic [14:0] QUARTER_SINE [0:64] = '{
        15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
        15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520, 15'd5897,
        15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076, 15'd8423, 15'd8765,
        15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394, 15'd10702, 15'd11003,
        15'd11297, 15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916,
        15'd13160, 15'd13395, 15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449,
        15'd14635, 15'd14811, 15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557,
        15'd15679, 15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
        15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
    };

    function automatic logic signed [15:0] sine_q14(input logic [7:0] a);
        logic [6:0]  r;
        logic [15:0] v;
        r = {1'b0, a[5:0]};
        v = a[6] ? {1'b0, QUARTER_SINE[7'd64 - r]} : {1'b0, QUARTER_SINE[r]};
        return a[7] ? 16'(-v) : v;
    endfunction

endpackage

### rtl/rotate_scale_blit_sampler_core.sv
// Top level of the rotate-and-scale blit sampler: pipeline, source store, config.
//
// Usage: raise i_start with one command (load or sample) on the input ports; the
// item transfers at every clock edge with i_start high, since o_busy stays low.
// A load writes i_src_value into the source store at i_src_index; it gives no
// result. A sample maps (i_dst_x, i_dst_y) back into the source by rotation and
// scaling and gives one result: o_valid is high for exactly one cycle with the
// destination point, the fetched source pixel and o_write_enable.
// One item is taken every cycle. The depth comes from the nine-stage restoring
// divider by the zoom, one quotient bit per stage for x and y side by side, plus
// the multiply, sum, address and store read stages around it.
// Loads travel the same pipeline and write the store at the stage where samples
// read it, so each sample sees exactly the loads that came before it.
// Config registers are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write them only while no item is in flight; the block does not enforce
// it. Reset clears the pipeline valid bits and sets the registers to their
// defaults; the source store is not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module rotate_scale_blit_sampler_core #(
    parameter int SRC_MAX_WIDTH  = 256,
    parameter int SRC_MAX_HEIGHT = 256,
    parameter int DST_MAX_DIM    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [15:0] i_src_index,
    input  logic [7:0]  i_src_value,
    input  logic [9:0]  i_dst_x,
    input  logic [9:0]  i_dst_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [9:0]  o_out_x,
    output logic [9:0]  o_out_y,
    output logic [7:0]  o_pixel,
    output logic        o_write_enable
);
    import rsb_pkg::*;

    localparam int STORE_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int NST = 15;
    localparam int S_DIV = 4;
    localparam logic [12:0] MAXW = 13'(SRC_MAX_WIDTH);
    localparam logic [12:0] MAXH = 13'(SRC_MAX_HEIGHT);
    localparam logic [13:0] DSTM = 14'(DST_MAX_DIM);
    localparam logic [24:0] DEPTH25 = 25'(STORE_DEPTH);

    // configuration
    logic [8:0]         r_src_width, r_src_height;
    logic signed [11:0] r_center_x, r_center_y;
    logic signed [15:0] r_zoom;
    logic [7:0]         r_angle;

    // pipeline
    t_item              r_it [0:NST-1];
    logic signed [12:0] r_rx, r_ry;
    logic signed [15:0] r_s, r_c;
    logic signed [28:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [25:0] r_wz, r_hz;
    logic signed [41:0] r_nx, r_ny;
    logic [40:0]        r_magx, r_magy;
    logic               r_negx [0:QW+1];
    logic               r_negy [0:QW+1];
    logic               r_ovfx [0:QW];
    logic               r_ovfy [0:QW];
    logic [40:0]        r_remx [0:QW];
    logic [40:0]        r_remy [0:QW];
    logic [QW-1:0]      r_qx [0:QW];
    logic [QW-1:0]      r_qy [0:QW];
    logic [21:0]        r_prod;
    logic [QW-1:0]      r_bx;
    logic               r_inb, r_inb2;
    logic [7:0]         r_rd;
    logic [7:0]         r_mem [0:STORE_DEPTH-1];
    logic               r_valid;
    logic [9:0]         r_out_x, r_out_y;
    logic [7:0]         r_pixel;
    logic               r_we;

    logic [8:0]  n_wc, n_hc;
    logic [15:0] n_dmag;
    logic [40:0] n_dsh [0:QW-1];
    logic [40:0] n_lim;
    logic [24:0] n_waddr, n_raddr;
    logic        n_inx, n_iny;
    t_item       n_in;

    assign o_busy = 1'b0;

    always_comb begin
        n_wc = (13'(r_src_width) > MAXW) ? MAXW[8:0] : r_src_width;
        n_hc = (13'(r_src_height) > MAXH) ? MAXH[8:0] : r_src_height;
        n_dmag = r_zoom[15] ? 16'(-r_zoom) : r_zoom;
        n_lim = 41'(n_dmag) << (FRAC + QW);
        for (int j = 0; j < QW; j++) begin
            n_dsh[j] = 41'(n_dmag) << (FRAC + QW - 1 - j);
        end
        n_in.vld = i_start;
        n_in.cmd = i_command;
        n_in.idx = i_src_index;
        n_in.val = i_src_value;
        n_in.dx  = i_dst_x;
        n_in.dy  = i_dst_y;
        n_in.ok  = (i_command == CMD_SAMPLE) && (r_zoom != 16'sd0)
                   && (14'(i_dst_x) < DSTM) && (14'(i_dst_y) < DSTM);
        n_inx = !r_ovfx[QW] && (r_qx[QW] < n_wc) && (r_qx[QW] == '0 || !r_negx[QW+1]);
        n_iny = !r_ovfy[QW] && (r_qy[QW] < n_hc) && (r_qy[QW] == '0 || !r_negy[QW+1]);
        n_waddr = 25'(r_it[NST-1].idx);
        n_raddr = 25'(r_prod) + 25'(r_bx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 9'd256;
            r_src_height <= 9'd256;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_zoom       <= 16'sd256;
            r_angle      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[8:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[8:0];
                CFG_CENTER_X:   r_center_x   <= i_cfg_data[11:0];
                CFG_CENTER_Y:   r_center_y   <= i_cfg_data[11:0];
                CFG_ZOOM:       r_zoom       <= i_cfg_data;
                CFG_ANGLE:      r_angle      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item control moves down one stage each cycle
    always_ff @(posedge i_clk) begin
        r_it[0] <= n_in;
        for (int i = 1; i < NST; i++) begin
            r_it[i] <= r_it[i-1];
        end
        r_valid <= r_it[NST-1].vld && r_it[NST-1].cmd == CMD_SAMPLE;
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_it[i].vld <= 1'b0;
            end
            r_valid <= 1'b0;
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        r_rx <= 13'(i_dst_x) - 13'(r_center_x);
        r_ry <= 13'(i_dst_y) - 13'(r_center_y);
        r_s  <= sine_q14(r_angle);
        r_c  <= sine_q14(r_angle + 8'd64);

        r_p1 <= 29'(r_s * r_rx);
        r_p2 <= 29'(r_c * r_ry);
        r_p3 <= 29'(r_s * r_ry);
        r_p4 <= 29'(r_c * r_rx);
        r_wz <= 26'($signed({1'b0, n_wc}) * r_zoom);
        r_hz <= 26'($signed({1'b0, n_hc}) * r_zoom);

        r_nx <= ((42'(r_p1) + 42'(r_p2)) <<< 8) + (42'(r_wz) <<< (FRAC - 1));
        r_ny <= ((42'(r_p3) - 42'(r_p4)) <<< 8) + (42'(r_hz) <<< (FRAC - 1));

        // sign of the quotient is the sign of numerator times the sign of zoom
        r_negx[0] <= r_nx[41] ^ r_zoom[15];
        r_negy[0] <= r_ny[41] ^ r_zoom[15];
        r_magx    <= r_nx[41] ? 41'(-r_nx) : 41'(r_nx);
        r_magy    <= r_ny[41] ? 41'(-r_ny) : 41'(r_ny);

        r_negx[1] <= r_negx[0];
        r_negy[1] <= r_negy[0];
        r_ovfx[0] <= r_magx >= n_lim;
        r_ovfy[0] <= r_magy >= n_lim;
        r_remx[0] <= r_magx;
        r_remy[0] <= r_magy;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;

        // one quotient bit per stage, most significant first
        for (int j = 0; j < QW; j++) begin
            r_negx[j+2] <= r_negx[j+1];
            r_negy[j+2] <= r_negy[j+1];
            r_ovfx[j+1] <= r_ovfx[j];
            r_ovfy[j+1] <= r_ovfy[j];
            if (r_remx[j] >= n_dsh[j]) begin
                r_remx[j+1] <= r_remx[j] - n_dsh[j];
                r_qx[j+1]   <= r_qx[j] | QW'(1 << (QW - 1 - j));
            end else begin
                r_remx[j+1] <= r_remx[j];
                r_qx[j+1]   <= r_qx[j];
            end
            if (r_remy[j] >= n_dsh[j]) begin
                r_remy[j+1] <= r_remy[j] - n_dsh[j];
                r_qy[j+1]   <= r_qy[j] | QW'(1 << (QW - 1 - j));
            end else begin
                r_remy[j+1] <= r_remy[j];
                r_qy[j+1]   <= r_qy[j];
            end
        end

        r_inb  <= n_inx && n_iny && r_it[S_DIV+QW].ok;
        r_bx   <= r_qx[QW];
        r_prod <= 22'(r_qy[QW] * 13'(n_wc));
        r_inb2 <= r_inb;
    end

    // source store: loads write and samples read at the same stage
    always_ff @(posedge i_clk) begin
        if (r_it[NST-1].vld && r_it[NST-1].cmd == CMD_LOAD && n_waddr < DEPTH25) begin
            r_mem[n_waddr[AW-1:0]] <= r_it[NST-1].val;
        end
        r_rd <= r_mem[n_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_out_x <= r_it[NST-1].dx;
        r_out_y <= r_it[NST-1].dy;
    end

    assign r_pixel = r_inb2 ? r_rd : 8'd0;
    assign r_we    = r_inb2 && (r_rd != 8'd0);

    assign o_valid        = r_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_pixel        = r_pixel;
    assign o_write_enable = r_we;

endmodule
